// ===== design/rist_pkg.sv =====
// Shared codes and the token control struct for the inode slot table.
// No dependencies; used by rist_cell and refcounted_inode_slot_table.
`timescale 1ns / 1ps

package rist_pkg;

  localparam int REQ_W    = 2;
  localparam int STATUS_W = 3;
  localparam int INODE_W  = 16;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 8;

  // request types
  localparam logic [REQ_W-1:0] REQ_GET   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUT   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NEW_LOAD    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DECREMENTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_RELEASED    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_IGNORED     = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SATURATED   = 3'd6;
  localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd7;

  // control part of the token that walks the cell row
  typedef struct packed {
    logic                valid;
    logic [REQ_W-1:0]    req;
    logic                done;        // request resolved by an earlier cell
    logic                free_found;  // a free slot has been seen
    logic [STATUS_W-1:0] status;
  } tok_ctl_t;

endpackage

// ===== design/refcounted_inode_slot_table.sv =====
// Reference-counted inode slot table: a row of SLOTS cells walked by a request token.
// Depends on rist_pkg and rist_cell.
`timescale 1ns / 1ps

// Usage
//   Requests go in on start with req_type_i, inode_num_i and slot_i and are
//   taken at a clock edge where start is high and busy is low. Each request
//   gives exactly one result on status_o, slot_out_o, inode_out_o and
//   count_out_o, shown for a single cycle with res_valid_o high.
// Timing
//   Get and put: the request travels down the row of cells, one cell per
//   cycle, and the result strobe rises once the token has left the last
//   cell and its result is registered; busy stays high meanwhile and drops
//   as the strobe rises, so the next request can go in during the strobe cycle.
//   Clear-all and the unused request type answer in the next cycle and keep
//   busy low, so they may come back to back.
// Reset
//   All reference counts go to zero and no request is in flight. Stored
//   inode numbers are not cleared; a slot is only read while its count is
//   nonzero.
// Results
//   There is no back-pressure: the receiver must take each result in the
//   cycle it is shown.
module refcounted_inode_slot_table #(
  parameter int SLOTS      = 64,
  parameter int COUNT_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [rist_pkg::REQ_W-1:0]    req_type_i,
  input  logic [rist_pkg::INODE_W-1:0]  inode_num_i,
  input  logic [rist_pkg::SLOT_W-1:0]   slot_i,
  output logic                          res_valid_o,
  output logic [rist_pkg::STATUS_W-1:0] status_o,
  output logic [rist_pkg::SLOT_W-1:0]   slot_out_o,
  output logic [rist_pkg::INODE_W-1:0]  inode_out_o,
  output logic [rist_pkg::COUNT_W-1:0]  count_out_o
);
  import rist_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);

  tok_ctl_t              tok_ctl  [SLOTS+1];
  logic [INODE_W-1:0]    tok_ino  [SLOTS+1];
  logic [SLOT_W-1:0]     tok_slot [SLOTS+1];
  logic [IDX_W-1:0]      tok_idx  [SLOTS+1];
  logic [COUNT_BITS-1:0] tok_cnt  [SLOTS+1];
  logic [SLOTS-1:0]      tok_live;

  logic                  accept;
  logic                  clear;
  logic                  claim;
  tok_ctl_t              last;

  logic                  busy_q, busy_d;
  logic                  valid_q, valid_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [INODE_W-1:0]    inode_q, inode_d;
  logic [COUNT_W-1:0]    count_q, count_d;

  assign accept = start && !busy_q;
  assign clear  = accept && (req_type_i == REQ_CLEAR);

  // token injected into the first cell
  assign tok_ctl[0]  = '{valid:      accept && ((req_type_i == REQ_GET) ||
                                                (req_type_i == REQ_PUT)),
                         req:        req_type_i,
                         done:       1'b0,
                         free_found: 1'b0,
                         status:     '0};
  assign tok_ino[0]  = inode_num_i;
  assign tok_slot[0] = slot_i;
  assign tok_idx[0]  = '0;
  assign tok_cnt[0]  = '0;

  assign last  = tok_ctl[SLOTS];
  // a get that found neither a hit nor a full table takes the lowest free slot
  assign claim = last.valid && (last.req == REQ_GET) && !last.done && last.free_found;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    rist_cell #(
      .IDX        (k),
      .IDX_W      (IDX_W),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .clear_i     (clear),
      .claim_i     (claim),
      .claim_idx_i (tok_idx[SLOTS]),
      .claim_ino_i (tok_ino[SLOTS]),
      .ctl_i       (tok_ctl[k]),
      .ino_i       (tok_ino[k]),
      .slot_i      (tok_slot[k]),
      .idx_i       (tok_idx[k]),
      .cnt_i       (tok_cnt[k]),
      .ctl_o       (tok_ctl[k+1]),
      .ino_o       (tok_ino[k+1]),
      .slot_o      (tok_slot[k+1]),
      .idx_o       (tok_idx[k+1]),
      .cnt_o       (tok_cnt[k+1])
    );
    assign tok_live[k] = tok_ctl[k+1].valid;
  end

  always_comb begin
    busy_d   = busy_q;
    valid_d  = 1'b0;
    status_d = status_q;
    slot_d   = slot_q;
    inode_d  = inode_q;
    count_d  = count_q;
    if (accept) begin
      case (req_type_i)
        REQ_CLEAR: begin
          valid_d  = 1'b1;
          status_d = ST_CLEARED;
          slot_d   = '0;
          inode_d  = '0;
          count_d  = '0;
        end
        REQ_NONE: begin
          valid_d  = 1'b1;
          status_d = ST_IGNORED;
          slot_d   = '0;
          inode_d  = '0;
          count_d  = '0;
        end
        default: begin
          busy_d = 1'b1;
        end
      endcase
    end else if (last.valid) begin
      busy_d  = 1'b0;
      valid_d = 1'b1;
      if (last.done) begin
        status_d = last.status;
        slot_d   = SLOT_W'(tok_idx[SLOTS]);
        inode_d  = tok_ino[SLOTS];
        count_d  = COUNT_W'(tok_cnt[SLOTS]);
      end else if (last.req == REQ_GET) begin
        inode_d = tok_ino[SLOTS];
        if (last.free_found) begin
          status_d = ST_NEW_LOAD;
          slot_d   = SLOT_W'(tok_idx[SLOTS]);
          count_d  = COUNT_W'(1);
        end else begin
          status_d = ST_FULL;
          slot_d   = '0;
          count_d  = '0;
        end
      end else begin
        // put on a slot index beyond the table
        status_d = ST_IGNORED;
        slot_d   = tok_slot[SLOTS];
        inode_d  = '0;
        count_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    slot_q   <= slot_d;
    inode_q  <= inode_d;
    count_q  <= count_d;
  end

  assign busy        = busy_q;
  assign res_valid_o = valid_q;
  assign status_o    = status_q;
  assign slot_out_o  = slot_q;
  assign inode_out_o = inode_q;
  assign count_out_o = count_q;

  // assertions
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_valid_o && busy_q))
    else $error("result shown while a request is still in the cell row");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_live) <= 1)
    else $error("more than one request token in the cell row");

  a_token_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_live != '0) |-> busy_q)
    else $error("request token in flight while not busy");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && tok_ctl[0].valid) |=> busy_q)
    else $error("get or put taken without going busy");

endmodule

// ===== design/rist_cell.sv =====
// One slot of the inode table: inode number, reference count and the token stage.
// Depends on rist_pkg.
`timescale 1ns / 1ps

module rist_cell #(
  parameter int IDX        = 0,
  parameter int IDX_W      = 6,
  parameter int COUNT_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      claim_i,
  input  logic [IDX_W-1:0]          claim_idx_i,
  input  logic [rist_pkg::INODE_W-1:0] claim_ino_i,
  input  rist_pkg::tok_ctl_t        ctl_i,
  input  logic [rist_pkg::INODE_W-1:0] ino_i,
  input  logic [rist_pkg::SLOT_W-1:0]  slot_i,
  input  logic [IDX_W-1:0]          idx_i,
  input  logic [COUNT_BITS-1:0]     cnt_i,
  output rist_pkg::tok_ctl_t        ctl_o,
  output logic [rist_pkg::INODE_W-1:0] ino_o,
  output logic [rist_pkg::SLOT_W-1:0]  slot_o,
  output logic [IDX_W-1:0]          idx_o,
  output logic [COUNT_BITS-1:0]     cnt_o
);
  import rist_pkg::*;

  localparam logic [IDX_W-1:0]      MY_IDX  = IDX_W'(IDX);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [INODE_W-1:0]    inode_q, inode_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  tok_ctl_t              ctl_q, ctl_d;
  logic [INODE_W-1:0]    ino_q, ino_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;

  always_comb begin
    inode_d = inode_q;
    count_d = count_q;
    ctl_d   = ctl_i;
    ino_d   = ino_i;
    slot_d  = slot_i;
    idx_d   = idx_i;
    cnt_d   = cnt_i;
    if (clear_i) begin
      count_d = '0;
    end else if (claim_i && (claim_idx_i == MY_IDX)) begin
      inode_d = claim_ino_i;
      count_d = COUNT_BITS'(1);
    end else if (ctl_i.valid && !ctl_i.done) begin
      case (ctl_i.req)
        REQ_GET: begin
          if ((count_q != '0) && (inode_q == ino_i)) begin
            ctl_d.done = 1'b1;
            idx_d      = MY_IDX;
            if (count_q == CNT_MAX) begin
              ctl_d.status = ST_SATURATED;
              cnt_d        = count_q;
            end else begin
              ctl_d.status = ST_HIT;
              count_d      = count_q + COUNT_BITS'(1);
              cnt_d        = count_q + COUNT_BITS'(1);
            end
          end else if ((count_q == '0) && !ctl_i.free_found) begin
            // lowest free slot so far; only used if no hit turns up
            ctl_d.free_found = 1'b1;
            idx_d            = MY_IDX;
          end
        end
        REQ_PUT: begin
          if (32'(slot_i) == IDX) begin
            ctl_d.done = 1'b1;
            idx_d      = MY_IDX;
            if (count_q == '0) begin
              ctl_d.status = ST_IGNORED;
              ino_d        = '0;
              cnt_d        = '0;
            end else begin
              count_d      = count_q - COUNT_BITS'(1);
              cnt_d        = count_q - COUNT_BITS'(1);
              ino_d        = inode_q;
              ctl_d.status = (count_q == COUNT_BITS'(1)) ? ST_RELEASED : ST_DECREMENTED;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ctl_q   <= '0;
    end else begin
      count_q <= count_d;
      ctl_q   <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inode_q <= inode_d;
    ino_q   <= ino_d;
    slot_q  <= slot_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
  end

  assign ctl_o  = ctl_q;
  assign ino_o  = ino_q;
  assign slot_o = slot_q;
  assign idx_o  = idx_q;
  assign cnt_o  = cnt_q;

endmodule
